@@ rtl/core/tjsm_pkg.sv @@
// shared constants, types and state codes for the tilt joystick speed mapper
`default_nettype none

package tjsm_pkg;

    // accelerometer sample width and derived datapath widths
    localparam int ACCEL_BITS = 11;
    localparam int OFF_W      = ACCEL_BITS + 1;
    localparam int DIFF_W     = ACCEL_BITS + 2;

    // fixed point constants
    localparam int Q_ONE        = 32768;
    localparam int Q_W          = 16;
    localparam int COUNTS_PER_G = 100;
    // floor(n * 32768 / 100) == (n * RECIP_100) >> RECIP_SHIFT for n below 100
    localparam int RECIP_100    = 1342178;
    localparam int RECIP_SHIFT  = 12;
    localparam int MAX_FWD      = 500000;
    localparam int MAX_TURN     = 6283185;
    localparam int FRAC_SHIFT   = 15;

    // shared multiplier
    localparam int MUL_A_W = 23;
    localparam int MUL_B_W = 21;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // shared divider
    localparam int DIV_N_W = 31;
    localparam int DIV_D_W = 16;
    localparam int DIV_Q_W = 16;
    localparam int DIV_C_W = 4;

    // result fields
    localparam int FWD_W  = 20;
    localparam int TURN_W = 24;
    localparam int AXIS_W = 2;

    localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
    localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
    localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

    // stream widths, padded to whole bytes
    localparam int S_FIELDS_W = 3 * ACCEL_BITS + 2;
    localparam int S_DATA_W   = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = FWD_W + TURN_W + AXIS_W + 1;
    localparam int M_DATA_W   = ((M_FIELDS_W + 7) / 8) * 8;

    typedef struct packed {
        logic               start;
        logic [DIV_N_W-1:0] numer;
        logic [DIV_D_W-1:0] denom;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic [DIV_Q_W-1:0] quot;
    } div_res_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CAL,
        ST_AXIS,
        ST_MULW,
        ST_DZ,
        ST_DIVW,
        ST_FWD,
        ST_TRN,
        ST_TRNW,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

@@ rtl/core/tjsm_mul.sv @@
// shared unsigned multiplier with registered product
`default_nettype none

module tjsm_mul (
    input  wire logic                          clk,
    input  wire logic [tjsm_pkg::MUL_A_W-1:0]  a,
    input  wire logic [tjsm_pkg::MUL_B_W-1:0]  b,
    output logic      [tjsm_pkg::MUL_P_W-1:0]  prod
);
    import tjsm_pkg::*;

    logic [MUL_P_W-1:0] prod_reg;
    logic [MUL_P_W-1:0] prod_next;

    assign prod_next = MUL_P_W'(a) * MUL_P_W'(b);

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

@@ rtl/core/tjsm_div.sv @@
// radix-2 restoring divider, one quotient bit per cycle
`default_nettype none

module tjsm_div (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire tjsm_pkg::div_req_t  req,
    output tjsm_pkg::div_res_t       res
);
    import tjsm_pkg::*;

    logic               busy_reg,  busy_next;
    logic               done_reg,  done_next;
    logic [DIV_C_W-1:0] cnt_reg,   cnt_next;
    logic [DIV_D_W-1:0] rem_reg,   rem_next;
    logic [DIV_Q_W-1:0] low_reg,   low_next;
    logic [DIV_D_W-1:0] den_reg,   den_next;

    logic [DIV_D_W:0]   trial;
    logic               ge;

    // remainder shifted left with the next numerator bit
    assign trial = {rem_reg, low_reg[DIV_Q_W-1]};
    assign ge    = trial >= {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        low_next  = low_reg;
        den_next  = den_reg;
        if (req.start && !busy_reg)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            // upper numerator part is already below the divisor
            rem_next  = {1'b0, req.numer[DIV_N_W-1:DIV_Q_W]};
            low_next  = req.numer[DIV_Q_W-1:0];
            den_next  = req.denom;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? DIV_D_W'(trial - {1'b0, den_reg}) : DIV_D_W'(trial);
            low_next = {low_reg[DIV_Q_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_C_W'(DIV_Q_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        low_reg <= low_next;
        den_reg <= den_next;
    end

    assign res.done = done_reg;
    assign res.quot = low_reg;

endmodule

`default_nettype wire

@@ rtl/core/tilt_joystick_speed_mapper.sv @@
// top level: sequencer, calibration state and result register of the speed mapper
//
// channel   dir  handshake              payload
// s_*       in   s_tvalid / s_tready    s_tdata  accel x, y, z, home, move
// m_*       out  m_tvalid / m_tready    m_tdata  forward, turn, axis, positive
// cfg_*     in   cfg_wr_en              cfg_wr_data  dead band, q0.15
//
// from accept to m_tvalid the sequencer runs a calibration state, then per axis the
// 1/100 multiply, product, dead band and divider states, then speed, turn and
// hand-off states; a full dead band skips the divider
// s_tready is high only while idle; an untaken result stalls the hand-off state
// the result register holds a finished word while the next one is accepted
// reset restores y as principal axis, negative direction, zero offsets

`default_nettype none

module tilt_joystick_speed_mapper (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // accel_x, accel_y, accel_z, home_pressed, move_pressed, zero pad
    input  wire logic [tjsm_pkg::S_DATA_W-1:0] s_tdata,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // forward_speed, turn_rate, main_axis, axis_positive, zero pad
    output logic      [tjsm_pkg::M_DATA_W-1:0] m_tdata,
    input  wire logic                          cfg_wr_en,
    input  wire logic [15:0]                   cfg_wr_data
);
    import tjsm_pkg::*;

    state_t state_reg, state_next;

    // configuration and calibration state
    logic [15:0]          dead_band_reg;
    logic [AXIS_W-1:0]    sel_reg;
    logic                 dir_reg;
    logic [OFF_W-1:0]     off_reg [3];

    // current sample
    logic [ACCEL_BITS-1:0] acc_reg [3];
    logic                  home_reg;
    logic                  move_reg;

    // per axis work registers
    logic [AXIS_W-1:0]    idx_reg;
    logic                 neg_reg;
    logic                 big_reg;
    logic [6:0]           n_reg;
    logic [Q_W-1:0]       vmag_reg;
    logic [Q_W-1:0]       a_mag_reg [3];
    logic                 a_neg_reg [3];
    logic [FWD_W-1:0]     fwd_reg;
    logic [TURN_W-1:0]    turn_reg;

    // result register
    logic                 out_valid_reg;
    logic [M_DATA_W-1:0]  out_data_reg;

    logic [MUL_A_W-1:0]   mul_a;
    logic [MUL_B_W-1:0]   mul_b;
    logic [MUL_P_W-1:0]   mul_p;
    div_req_t             div_req;
    div_res_t             div_res;

    logic                 accept;
    logic                 out_free;

    tjsm_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (mul_p)
    );

    tjsm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .res   (div_res)
    );

    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    // ---------------- calibration ----------------
    logic [ACCEL_BITS-1:0] mag [3];
    logic [ACCEL_BITS-1:0] s_acc [3];
    logic [AXIS_W-1:0]     cal_sel;
    logic                  cal_dir;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            mag[i] = acc_reg[i][ACCEL_BITS-1] ? (~acc_reg[i] + 1'b1) : acc_reg[i];
        end
        cal_sel = sel_reg;
        if (mag[0] > mag[1] && mag[0] > mag[2])
        begin
            cal_sel = AXIS_X;
        end
        else if (mag[1] > mag[0] && mag[1] > mag[2])
        begin
            cal_sel = AXIS_Y;
        end
        else if (mag[2] > mag[0] && mag[2] > mag[1])
        begin
            cal_sel = AXIS_Z;
        end
        cal_dir = !acc_reg[cal_sel][ACCEL_BITS-1];
    end

    // unpack input word
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            s_acc[i] = s_tdata[i*ACCEL_BITS +: ACCEL_BITS];
        end
    end

    // ---------------- axis datapath ----------------
    logic signed [DIFF_W-1:0] diff;
    logic        [DIFF_W-1:0] dmag;
    logic                     dneg;
    logic [Q_W-1:0]           dz;
    logic                     dz_full;
    logic [Q_W-1:0]           den;
    logic [Q_W-1:0]           w;

    assign diff = DIFF_W'($signed(acc_reg[idx_reg])) - DIFF_W'($signed(off_reg[idx_reg]));
    assign dneg = diff[DIFF_W-1];
    assign dmag = dneg ? DIFF_W'(-diff) : DIFF_W'(diff);

    assign dz_full = dead_band_reg[15];
    assign dz      = dz_full ? Q_W'(Q_ONE) : dead_band_reg;
    assign den     = Q_W'(Q_ONE) - dz;
    assign w       = (vmag_reg < dz) ? '0 : (vmag_reg - dz);

    // ---------------- result mapping ----------------
    logic              use_ref;
    logic [AXIS_W-1:0] ref_idx;
    logic [Q_W-1:0]    ref_mag;
    logic              ref_neg;
    logic [FWD_W-1:0]  fwd_mag;
    logic [TURN_W-1:0] turn_mag;
    logic              turn_neg;

    assign use_ref = move_reg &&
                     ((sel_reg == AXIS_Y && !dir_reg) ||
                      ((sel_reg == AXIS_Y || sel_reg == AXIS_Z) && dir_reg));
    assign ref_idx  = (sel_reg == AXIS_Y && !dir_reg) ? AXIS_Z : AXIS_Y;
    assign ref_mag  = a_mag_reg[ref_idx];
    assign ref_neg  = a_neg_reg[ref_idx];
    assign fwd_mag  = mul_p[FRAC_SHIFT +: FWD_W];
    assign turn_mag = mul_p[FRAC_SHIFT +: TURN_W];
    // turn follows x, flipped unless the reference axis is negative
    assign turn_neg = a_neg_reg[0] ^ !ref_neg;

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_CAL;
                end
            end
            ST_CAL:  state_next = ST_AXIS;
            ST_AXIS: state_next = ST_MULW;
            ST_MULW: state_next = ST_DZ;
            ST_DZ:
            begin
                if (dz_full)
                begin
                    state_next = (idx_reg == AXIS_Z) ? ST_FWD : ST_AXIS;
                end
                else
                begin
                    state_next = ST_DIVW;
                end
            end
            ST_DIVW:
            begin
                if (div_res.done)
                begin
                    state_next = (idx_reg == AXIS_Z) ? ST_FWD : ST_AXIS;
                end
            end
            ST_FWD:  state_next = ST_TRN;
            ST_TRN:  state_next = ST_TRNW;
            ST_TRNW: state_next = ST_DONE;
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_tready      = 1'b0;
        mul_a         = '0;
        mul_b         = '0;
        div_req.start = 1'b0;
        div_req.numer = {w, {FRAC_SHIFT{1'b0}}};
        div_req.denom = den;
        case (state_reg)
            ST_IDLE: s_tready = 1'b1;
            ST_AXIS:
            begin
                mul_a = MUL_A_W'(RECIP_100);
                mul_b = MUL_B_W'(dmag[6:0]);
            end
            ST_DZ:   div_req.start = !dz_full;
            ST_FWD:
            begin
                mul_a = MUL_A_W'(MAX_FWD);
                mul_b = MUL_B_W'(ref_mag);
            end
            ST_TRN:
            begin
                mul_a = MUL_A_W'(MAX_TURN);
                mul_b = MUL_B_W'(a_mag_reg[0]);
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    // ---------------- control registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            dead_band_reg <= '0;
            sel_reg       <= AXIS_Y;
            dir_reg       <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                off_reg[i] <= '0;
            end
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                dead_band_reg <= cfg_wr_data;
            end
            if (state_reg == ST_CAL && home_reg)
            begin
                sel_reg <= cal_sel;
                dir_reg <= cal_dir;
                for (int i = 0; i < 3; i++)
                begin
                    // principal offset moves one g against its sign
                    if (AXIS_W'(i) == cal_sel)
                    begin
                        off_reg[i] <= cal_dir ?
                            OFF_W'($signed(acc_reg[i])) - OFF_W'(COUNTS_PER_G) :
                            OFF_W'($signed(acc_reg[i])) + OFF_W'(COUNTS_PER_G);
                    end
                    else
                    begin
                        off_reg[i] <= OFF_W'($signed(acc_reg[i]));
                    end
                end
            end
            if (state_reg == ST_CAL)
            begin
                idx_reg <= AXIS_X;
            end
            else if ((state_reg == ST_DZ && dz_full) ||
                     (state_reg == ST_DIVW && div_res.done))
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (state_reg == ST_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int i = 0; i < 3; i++)
            begin
                acc_reg[i] <= s_acc[i];
            end
            home_reg <= s_tdata[3*ACCEL_BITS];
            move_reg <= s_tdata[3*ACCEL_BITS+1];
        end
        if (state_reg == ST_AXIS)
        begin
            neg_reg <= dneg;
            big_reg <= dmag >= DIFF_W'(COUNTS_PER_G);
            n_reg   <= dmag[6:0];
        end
        if (state_reg == ST_MULW)
        begin
            // one g or more saturates to full scale
            vmag_reg <= big_reg ? Q_W'(Q_ONE) : mul_p[RECIP_SHIFT +: Q_W];
        end
        if (state_reg == ST_DZ && dz_full)
        begin
            a_mag_reg[idx_reg] <= '0;
            a_neg_reg[idx_reg] <= 1'b0;
        end
        if (state_reg == ST_DIVW && div_res.done)
        begin
            a_mag_reg[idx_reg] <= div_res.quot;
            a_neg_reg[idx_reg] <= neg_reg && (div_res.quot != '0) && (n_reg != 7'd0 || big_reg);
        end
        if (state_reg == ST_TRN)
        begin
            fwd_reg <= !use_ref ? '0 : (ref_neg ? FWD_W'(-fwd_mag) : fwd_mag);
        end
        if (state_reg == ST_TRNW)
        begin
            turn_reg <= !use_ref ? '0 : (turn_neg ? TURN_W'(-turn_mag) : turn_mag);
        end
        if (state_reg == ST_DONE && out_free)
        begin
            out_data_reg <= M_DATA_W'({dir_reg, sel_reg, turn_reg, fwd_reg});
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire
